>>> design/radius_neighbor_filter_unit_defines.svh
// assertion macros shared by the radius neighbor filter
`ifndef RADIUS_NEIGHBOR_FILTER_UNIT_DEFINES_SVH
`define RADIUS_NEIGHBOR_FILTER_UNIT_DEFINES_SVH

// condition must never hold outside reset
`define RNF_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

// same-cycle implication
`define RNF_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RNF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/rnf_pkg.sv
package rnf_pkg;

    localparam int MAX_REFS_DEF = 64;

    localparam int COORD_W  = 24;
    localparam int MAG_W    = 24;
    localparam int SQ_W     = 48;
    localparam int SUM_W    = 50;
    localparam int RADIUS_W = 23;
    localparam int R2_W     = 46;
    localparam int INDEX_W  = 16;

    localparam logic [1:0] KIND_LOAD  = 2'd0;
    localparam logic [1:0] KIND_TEST  = 2'd1;
    localparam logic [1:0] KIND_CLEAR = 2'd2;

    localparam logic REG_RADIUS = 1'b0;

    typedef struct packed {
        logic        [1:0]         kind;
        logic signed [COORD_W-1:0] coord_x;
        logic signed [COORD_W-1:0] coord_y;
        logic signed [COORD_W-1:0] coord_z;
        logic        [INDEX_W-1:0] atom_index;
        logic                      query_end;
    } t_in_item;

    typedef struct packed {
        logic [INDEX_W-1:0] result_index;
        logic               within_res;
        logic               last;
        logic               none_found;
    } t_out_item;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
    } t_point;

    typedef struct packed {
        logic valid;
        logic last;
    } t_issue;

    typedef struct packed {
        logic valid;
        logic last;
        logic hit;
    } t_dist_res;

endpackage

>>> design/rnf_ram.sv
module rnf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/rnf_dist.sv
module rnf_dist (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_flush,
    input  rnf_pkg::t_issue                  i_issue,
    input  rnf_pkg::t_point                  i_ref,
    input  rnf_pkg::t_point                  i_pt,
    input  logic [rnf_pkg::R2_W-1:0]         i_r2,
    output rnf_pkg::t_dist_res               o_res
);

    rnf_pkg::t_issue r_s0, r_s1, r_s2, r_s3;
    rnf_pkg::t_issue n_s0, n_s1, n_s2, n_s3;

    logic [rnf_pkg::MAG_W-1:0] r_mag_x, r_mag_y, r_mag_z;
    logic [rnf_pkg::MAG_W-1:0] n_mag_x, n_mag_y, n_mag_z;
    logic [rnf_pkg::SQ_W-1:0]  r_sq_x, r_sq_y, r_sq_z;
    logic [rnf_pkg::SQ_W-1:0]  n_sq_x, n_sq_y, n_sq_z;
    logic [rnf_pkg::SUM_W-1:0] r_sum;
    logic [rnf_pkg::SUM_W-1:0] n_sum;

    function automatic logic [rnf_pkg::MAG_W-1:0] abs_diff(
        input logic signed [rnf_pkg::COORD_W-1:0] a,
        input logic signed [rnf_pkg::COORD_W-1:0] b
    );
        logic signed [rnf_pkg::COORD_W:0] d;
        logic        [rnf_pkg::COORD_W:0] m;
        d = {a[rnf_pkg::COORD_W-1], a} - {b[rnf_pkg::COORD_W-1], b};
        m = d[rnf_pkg::COORD_W] ? -d : d;
        return m[rnf_pkg::MAG_W-1:0];
    endfunction

    always_comb begin
        n_s0 = i_issue;
        n_s1 = r_s0;
        n_s2 = r_s1;
        n_s3 = r_s2;
        if (i_flush) begin
            n_s0.valid = 1'b0;
            n_s1.valid = 1'b0;
            n_s2.valid = 1'b0;
            n_s3.valid = 1'b0;
        end
    end

    // stage 1: magnitudes of the differences against the ram word
    assign n_mag_x = abs_diff(i_ref.x, i_pt.x);
    assign n_mag_y = abs_diff(i_ref.y, i_pt.y);
    assign n_mag_z = abs_diff(i_ref.z, i_pt.z);

    // stage 2: one square per axis
    assign n_sq_x = r_mag_x * r_mag_x;
    assign n_sq_y = r_mag_y * r_mag_y;
    assign n_sq_z = r_mag_z * r_mag_z;

    // stage 3: exact sum of squares
    assign n_sum = {2'b00, r_sq_x} + {2'b00, r_sq_y} + {2'b00, r_sq_z};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0 <= '0;
            r_s1 <= '0;
            r_s2 <= '0;
            r_s3 <= '0;
        end else begin
            r_s0 <= n_s0;
            r_s1 <= n_s1;
            r_s2 <= n_s2;
            r_s3 <= n_s3;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mag_x <= n_mag_x;
        r_mag_y <= n_mag_y;
        r_mag_z <= n_mag_z;
        r_sq_x  <= n_sq_x;
        r_sq_y  <= n_sq_y;
        r_sq_z  <= n_sq_z;
        r_sum   <= n_sum;
    end

    assign o_res.valid = r_s3.valid;
    assign o_res.last  = r_s3.last;
    assign o_res.hit   = r_sum < {{(rnf_pkg::SUM_W - rnf_pkg::R2_W){1'b0}}, i_r2};

endmodule

>>> design/radius_neighbor_filter_unit.sv
// Radius neighbor filter: stores up to MAX_REFS reference points (load words
// append, clear words empty the table) and checks each test atom for a squared
// distance strictly below radius squared against any stored point, stopping at
// the first match. A result word comes out for every atom that matches and for
// the atom that ends a query; on the latter none_found flags a query without
// any match. Load and clear words are handled without leaving idle. For a
// test word one stored point per cycle is read from the point ram and
// streamed through the shared four-stage squared-distance unit, then the
// pipeline drains and the result is handed off; a match cuts the scan
// short. The block takes no new word while a test is in progress. The point
// ram needs no initialization after reset, only entries below the fill count
// are ever read.
module radius_neighbor_filter_unit #(
    parameter int MAX_REFS = rnf_pkg::MAX_REFS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,

    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  rnf_pkg::t_in_item  i_in_data,

    output logic               o_out_valid,
    input  logic               i_out_stall,
    output rnf_pkg::t_out_item o_out_data,

    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int AW = (MAX_REFS > 1) ? $clog2(MAX_REFS) : 1;
    localparam int CW = $clog2(MAX_REFS + 1);
    localparam logic [CW-1:0] MaxCount = CW'(MAX_REFS);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_RUN   = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0]                    r_state, n_state;
    logic [CW-1:0]                 r_ref_count, n_ref_count;
    logic [AW-1:0]                 r_issue, n_issue;
    logic                          r_hit, n_hit;
    logic                          r_any_hit, n_any_hit;
    logic                          r_out_valid, n_out_valid;
    logic [rnf_pkg::RADIUS_W-1:0]  r_radius;
    logic [rnf_pkg::R2_W-1:0]      r_r2, n_r2;
    rnf_pkg::t_in_item             r_item;
    rnf_pkg::t_out_item            r_out_data, n_out_data;

    logic                          in_acc;
    logic                          cfg_wr;
    logic                          ram_we;
    logic                          flush;
    logic                          last_issue;
    rnf_pkg::t_issue               issue;
    rnf_pkg::t_point               ram_rdata;
    rnf_pkg::t_point               ram_wdata;
    rnf_pkg::t_point               test_pt;
    rnf_pkg::t_dist_res            dres;

    assign in_acc     = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == rnf_pkg::REG_RADIUS);
    assign prdata = (paddr[2] == rnf_pkg::REG_RADIUS)
                  ? {{(32 - rnf_pkg::RADIUS_W){1'b0}}, r_radius} : 32'd0;
    assign n_r2   = r_radius * r_radius;

    assign ram_wdata.x = i_in_data.coord_x;
    assign ram_wdata.y = i_in_data.coord_y;
    assign ram_wdata.z = i_in_data.coord_z;

    assign test_pt.x = r_item.coord_x;
    assign test_pt.y = r_item.coord_y;
    assign test_pt.z = r_item.coord_z;

    assign last_issue = ({{(CW - AW){1'b0}}, r_issue} == (r_ref_count - CW'(1)));

    rnf_ram #(
        .WIDTH ($bits(rnf_pkg::t_point)),
        .DEPTH (MAX_REFS)
    ) u_points (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_ref_count[AW-1:0]),
        .i_wdata (ram_wdata),
        .i_raddr (r_issue),
        .o_rdata (ram_rdata)
    );

    rnf_dist u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flush (flush),
        .i_issue (issue),
        .i_ref   (ram_rdata),
        .i_pt    (test_pt),
        .i_r2    (r_r2),
        .o_res   (dres)
    );

    always_comb begin
        n_state     = r_state;
        n_ref_count = r_ref_count;
        n_issue     = r_issue;
        n_hit       = r_hit;
        n_any_hit   = r_any_hit;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_data  = r_out_data;
        ram_we      = 1'b0;
        flush       = 1'b0;
        issue       = '0;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    unique case (i_in_data.kind)
                        rnf_pkg::KIND_LOAD: begin
                            if (r_ref_count != MaxCount) begin
                                ram_we      = 1'b1;
                                n_ref_count = r_ref_count + CW'(1);
                            end
                        end
                        rnf_pkg::KIND_CLEAR: begin
                            n_ref_count = '0;
                        end
                        rnf_pkg::KIND_TEST: begin
                            n_hit   = 1'b0;
                            n_issue = '0;
                            n_state = (r_ref_count == '0) ? S_DONE : S_RUN;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_RUN: begin
                if (dres.valid && dres.hit) begin
                    n_hit   = 1'b1;
                    flush   = 1'b1;
                    n_state = S_DONE;
                end else begin
                    issue.valid = 1'b1;
                    issue.last  = last_issue;
                    n_issue     = r_issue + AW'(1);
                    if (last_issue) begin
                        n_state = S_DRAIN;
                    end
                end
            end
            S_DRAIN: begin
                if (dres.valid) begin
                    if (dres.hit) begin
                        n_hit   = 1'b1;
                        flush   = 1'b1;
                        n_state = S_DONE;
                    end else if (dres.last) begin
                        n_state = S_DONE;
                    end
                end
            end
            S_DONE: begin
                // a miss in the middle of a query gives no word
                if (!r_hit && !r_item.query_end) begin
                    n_state = S_IDLE;
                end else if (!r_out_valid || !i_out_stall) begin
                    n_out_valid             = 1'b1;
                    n_out_data.result_index = r_item.atom_index;
                    n_out_data.within_res   = r_hit;
                    n_out_data.last         = r_item.query_end;
                    n_out_data.none_found   = r_item.query_end && !(r_any_hit || r_hit);
                    n_any_hit               = !r_item.query_end;
                    n_state                 = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ref_count <= '0;
            r_issue     <= '0;
            r_hit       <= 1'b0;
            r_any_hit   <= 1'b0;
            r_out_valid <= 1'b0;
            r_radius    <= '0;
            r_r2        <= '0;
        end else begin
            r_state     <= n_state;
            r_ref_count <= n_ref_count;
            r_issue     <= n_issue;
            r_hit       <= n_hit;
            r_any_hit   <= n_any_hit;
            r_out_valid <= n_out_valid;
            r_r2        <= n_r2;
            if (cfg_wr) begin
                r_radius <= pwdata[rnf_pkg::RADIUS_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_item <= i_in_data;
        end
        r_out_data <= n_out_data;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

`include "radius_neighbor_filter_unit_defines.svh"

    `RNF_ASSERT_NEVER(a_count_bound, i_clk, i_rst_n, r_ref_count > MaxCount, "fill count overflow")
    `RNF_ASSERT_IMPLIES(a_res_in_scan, i_clk, i_rst_n, dres.valid, (r_state == S_RUN) || (r_state == S_DRAIN), "distance result outside a scan")
    `RNF_ASSERT_IMPLIES(a_none_last, i_clk, i_rst_n, o_out_valid && o_out_data.none_found, o_out_data.last, "none_found without last")
    `RNF_ASSERT_NEXT(a_load_count, i_clk, i_rst_n, in_acc && (i_in_data.kind == rnf_pkg::KIND_LOAD) && (r_ref_count != MaxCount), r_ref_count == $past(r_ref_count) + CW'(1), "load did not advance fill count")

endmodule
